// File: hw/rtl/sacd_pkg.sv
// Shared constants and types for the set-associative cache directory.
package sacd_pkg;

  localparam int unsigned AddrBits   = 32;
  localparam int unsigned OffsetBits = 3;
  localparam int unsigned SetBits    = 14;
  localparam int unsigned NumWays    = 4;
  localparam int unsigned CountBits  = 32;

  localparam int unsigned TagLsb   = OffsetBits + SetBits;
  localparam int unsigned TagBits  = AddrBits - TagLsb;
  localparam int unsigned NumSets  = 2 ** SetBits;
  localparam int unsigned WayBits  = $clog2(NumWays);
  localparam int unsigned RankBits = WayBits;
  localparam int unsigned LineBits = TagBits + SetBits;

  typedef enum logic [1:0] {
    OutcomeHit      = 2'd0,
    OutcomeCold     = 2'd1,
    OutcomeConflict = 2'd2
  } outcome_e;

  typedef logic [NumWays-1:0][TagBits-1:0] tag_row_t;

  typedef struct packed {
    logic [NumWays-1:0]               valid;
    logic [NumWays-1:0]               dirty;
    logic [NumWays-1:0][RankBits-1:0] rank;
  } set_stat_t;

  typedef struct packed {
    outcome_e              outcome;
    logic [WayBits-1:0]    way;
    logic                  fill_line;
    logic                  evict_dirty;
    logic [LineBits-1:0]   victim_line;
  } access_res_t;

endpackage

// File: hw/rtl/sacd_update.sv
// Lookup, victim choice and LRU/valid/dirty/tag update for one set.
module sacd_update (
  input  logic                         write_i,
  input  logic [sacd_pkg::TagBits-1:0] tag_i,
  input  logic [sacd_pkg::SetBits-1:0] set_i,
  input  sacd_pkg::set_stat_t          stat_i,
  input  sacd_pkg::tag_row_t           tags_i,
  output sacd_pkg::set_stat_t          stat_o,
  output sacd_pkg::tag_row_t           tags_o,
  output sacd_pkg::access_res_t        res_o
);

  logic                           hit;
  logic                           empty;
  logic [sacd_pkg::WayBits-1:0]   hit_way;
  logic [sacd_pkg::WayBits-1:0]   empty_way;
  logic [sacd_pkg::WayBits-1:0]   lru_way;
  logic [sacd_pkg::WayBits-1:0]   way;
  logic [sacd_pkg::RankBits-1:0]  old_rank;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    lru_way   = '0;
    for (int k = 0; k < sacd_pkg::NumWays; k++) begin
      if (!hit && stat_i.valid[k] && (tags_i[k] == tag_i)) begin
        hit     = 1'b1;
        hit_way = sacd_pkg::WayBits'(k);
      end
      if (!empty && !stat_i.valid[k]) begin
        empty     = 1'b1;
        empty_way = sacd_pkg::WayBits'(k);
      end
    end
    // strict compare keeps the lowest way on a tie
    for (int k = 1; k < sacd_pkg::NumWays; k++) begin
      if (stat_i.rank[k] > stat_i.rank[lru_way]) begin
        lru_way = sacd_pkg::WayBits'(k);
      end
    end

    res_o = '0;
    if (hit) begin
      way            = hit_way;
      old_rank       = stat_i.rank[hit_way];
      res_o.outcome  = sacd_pkg::OutcomeHit;
    end else if (empty) begin
      way            = empty_way;
      old_rank       = sacd_pkg::RankBits'(sacd_pkg::NumWays - 1);
      res_o.outcome  = sacd_pkg::OutcomeCold;
      res_o.fill_line = !write_i;
    end else begin
      way               = lru_way;
      old_rank          = stat_i.rank[lru_way];
      res_o.outcome     = sacd_pkg::OutcomeConflict;
      res_o.fill_line   = !write_i;
      res_o.evict_dirty = stat_i.dirty[lru_way];
      res_o.victim_line = {tags_i[lru_way], set_i};
    end
    res_o.way = way;

    stat_o = stat_i;
    tags_o = tags_i;
    for (int k = 0; k < sacd_pkg::NumWays; k++) begin
      if ((sacd_pkg::WayBits'(k) != way) && stat_i.valid[k] && (stat_i.rank[k] < old_rank)) begin
        stat_o.rank[k] = stat_i.rank[k] + 1'b1;
      end
    end
    stat_o.rank[way]  = '0;
    stat_o.valid[way] = 1'b1;
    if (hit) begin
      stat_o.dirty[way] = stat_i.dirty[way] | write_i;
    end else begin
      stat_o.dirty[way] = write_i;
      tags_o[way]       = tag_i;
    end
  end

endmodule

// File: hw/rtl/set_assoc_cache_directory_lru.sv
// Top level: 4-way write-back cache directory with true LRU and hit/miss counters.
// The accepting edge reads the memories into stage 1; the result is registered when stage 1 advances.
// Throughput: one transaction per cycle while out_stall_i is low and no clear pass runs; a
//   transaction to the set last written takes the bypassed row, not the stale memory read.
// Reset: counters and control clear at once; the status memory (valid, dirty, rank) is
//   cleared by a pass over all sets, one set per cycle, with in_stall_o high. Tags are not cleared.
module set_assoc_cache_directory_lru (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [sacd_pkg::AddrBits-1:0]   address_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      outcome_o,
  output logic [sacd_pkg::WayBits-1:0]    way_o,
  output logic                            fill_line_o,
  output logic                            evict_dirty_o,
  output logic [sacd_pkg::LineBits-1:0]   victim_line_o,
  output logic [sacd_pkg::CountBits-1:0]  hits_so_far_o,
  output logic [sacd_pkg::CountBits-1:0]  misses_so_far_o
);

  sacd_pkg::set_stat_t stat_mem [sacd_pkg::NumSets];
  sacd_pkg::tag_row_t  tag_mem  [sacd_pkg::NumSets];

  logic                          clr_active_q;
  logic [sacd_pkg::SetBits-1:0]  clr_idx_q;

  logic                          in_accept;
  logic                          s1_adv;
  logic [sacd_pkg::SetBits-1:0]  in_set;

  logic                          s1_valid_q;
  logic                          s1_write_q;
  logic [sacd_pkg::SetBits-1:0]  s1_set_q;
  logic [sacd_pkg::TagBits-1:0]  s1_tag_q;
  sacd_pkg::set_stat_t           rd_stat_q;
  sacd_pkg::tag_row_t            rd_tags_q;

  logic                          byp_valid_q;
  logic [sacd_pkg::SetBits-1:0]  byp_set_q;
  sacd_pkg::set_stat_t           byp_stat_q;
  sacd_pkg::tag_row_t            byp_tags_q;

  logic                          byp_hit;
  sacd_pkg::set_stat_t           cur_stat;
  sacd_pkg::tag_row_t            cur_tags;
  sacd_pkg::set_stat_t           new_stat;
  sacd_pkg::tag_row_t            new_tags;
  sacd_pkg::access_res_t         upd_res;

  logic                          out_valid_q;
  sacd_pkg::access_res_t         out_res_q;
  logic [sacd_pkg::CountBits-1:0] hit_cnt_q;
  logic [sacd_pkg::CountBits-1:0] miss_cnt_q;

  assign in_set = address_i[sacd_pkg::OffsetBits +: sacd_pkg::SetBits];

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  // most recent write wins over the memory read
  assign byp_hit  = byp_valid_q && (byp_set_q == s1_set_q);
  assign cur_stat = byp_hit ? byp_stat_q : rd_stat_q;
  assign cur_tags = byp_hit ? byp_tags_q : rd_tags_q;

  sacd_update u_update (
    .write_i (s1_write_q),
    .tag_i   (s1_tag_q),
    .set_i   (s1_set_q),
    .stat_i  (cur_stat),
    .tags_i  (cur_tags),
    .stat_o  (new_stat),
    .tags_o  (new_tags),
    .res_o   (upd_res)
  );

  // status memory: clear pass port shares the single write port
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      stat_mem[clr_idx_q] <= '0;
    end else if (s1_adv) begin
      stat_mem[s1_set_q] <= new_stat;
    end
    if (in_accept) begin
      rd_stat_q <= stat_mem[in_set];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      tag_mem[s1_set_q] <= new_tags;
    end
    if (in_accept) begin
      rd_tags_q <= tag_mem[in_set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
    end else if (clr_active_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == '1) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        byp_valid_q <= 1'b1;
        out_valid_q <= 1'b1;
        if (upd_res.outcome == sacd_pkg::OutcomeHit) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_write_q <= action_i;
      s1_set_q   <= in_set;
      s1_tag_q   <= address_i[sacd_pkg::AddrBits-1:sacd_pkg::TagLsb];
    end
    if (s1_adv) begin
      byp_set_q  <= s1_set_q;
      byp_stat_q <= new_stat;
      byp_tags_q <= new_tags;
      out_res_q  <= upd_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = out_res_q.outcome;
  assign way_o           = out_res_q.way;
  assign fill_line_o     = out_res_q.fill_line;
  assign evict_dirty_o   = out_res_q.evict_dirty;
  assign victim_line_o   = out_res_q.victim_line;
  assign hits_so_far_o   = hit_cnt_q;
  assign misses_so_far_o = miss_cnt_q;

  // each completed lookup bumps exactly one of the two counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (hit_cnt_q + miss_cnt_q) == ($past(hit_cnt_q) + $past(miss_cnt_q) + 1'b1))
    else $error("hit/miss counters did not advance by one");

  // a conflict miss only happens in a full set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (upd_res.outcome == sacd_pkg::OutcomeConflict)) |-> (&cur_stat.valid))
    else $error("conflict miss with an empty way");

  // write-back is reported only for an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.evict_dirty) |-> (out_res_q.outcome == sacd_pkg::OutcomeConflict))
    else $error("write-back without conflict miss");

  // nothing enters the pipeline while the status memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |=> !s1_valid_q || !$past(clr_active_q))
    else $error("transaction accepted during clear pass");

endmodule
